@@ rtl/bsl_pkg.sv @@
// package: shared types, codes and constants of the button press detector
package bsl_pkg;

  // number of buttons with a machine of their own
  localparam int unsigned NUM_BUTTONS = 4;
  // pin bits carried by one sample beat
  localparam int unsigned PIN_W       = 4;
  // event fields carried by one result beat
  localparam int unsigned OUT_FIELDS  = 4;
  localparam int unsigned EV_W        = 2;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 6'd2;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 6'd60;
  localparam logic [CFG_W-1:0] HOLDOFF_RST    = 6'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 2'd2;

  // beat kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_ACK    = 1'b1;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

  // thresholds as seen by every button
  typedef struct packed {
    logic [CFG_W-1:0] min_press;
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] holdoff;
  } cfg_t;

endpackage

@@ rtl/bsl_cfg_regs.sv @@
// configuration registers of the button press detector
module bsl_cfg_regs
  import bsl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_PRESS:  cfg_d.min_press  = cfg_data_i;
        CFG_LONG_PRESS: cfg_d.long_press = cfg_data_i;
        CFG_HOLDOFF:    cfg_d.holdoff    = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_press  <= MIN_PRESS_RST;
      cfg_q.long_press <= LONG_PRESS_RST;
      cfg_q.holdoff    <= HOLDOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/bsl_button_fsm.sv @@
// per-button press machine: phase and tick count, next event
module bsl_button_fsm
  import bsl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            func_i,
  input  logic            released_i,
  input  cfg_t            cfg_i,
  output logic [EV_W-1:0] event_o
);

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_HOLD  = 2'd1,
    PH_SHORT = 2'd2,
    PH_LONG  = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] bump;

  // saturating increment
  assign bump = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 6'd1;

  // next phase and count for this beat
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (func_i == FUNC_SAMPLE) begin
      unique case (phase_q)
        PH_COUNT: begin
          if (!released_i) begin
            if (bump >= cfg_i.long_press) begin
              phase_d = PH_LONG;
              cnt_d   = '0;
            end else begin
              cnt_d = bump;
            end
          end else if (cnt_q >= cfg_i.min_press) begin
            phase_d = PH_SHORT;
            cnt_d   = '0;
          end
        end
        PH_HOLD: begin
          if (released_i) begin
            if (bump >= cfg_i.holdoff) begin
              phase_d = PH_COUNT;
              cnt_d   = '0;
            end else begin
              cnt_d = bump;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end else if (released_i && (phase_q == PH_SHORT || phase_q == PH_LONG)) begin
      phase_d = PH_HOLD;
      cnt_d   = '0;
    end
  end

  // state advances only when the beat moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // event after this beat
  always_comb begin
    unique case (phase_d)
      PH_SHORT: event_o = EV_SHORT;
      PH_LONG:  event_o = EV_LONG;
      default:  event_o = EV_NONE;
    endcase
  end

endmodule

@@ rtl/button_short_long_press_detector.sv @@
// top level: short/long press detector for active-low buttons
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pins_released; tuser: func
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: event_button0..3
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// one beat per cycle sustained while the result is taken; an accepted beat passes
// the input register, then the button update into the result register
// reset clears all buttons to the counting phase with a zero count and loads
// the threshold defaults; a stalled result holds while one more beat waits in
// the input register, after which s_axis_tready drops
module button_short_long_press_detector
  import bsl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [3:0] pins_released, [7:4] zero
  input  logic                 s_axis_tuser,   // [0] func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [1:0] event_button0, [3:2] event_button1,
                                               // [5:4] event_button2, [7:6] event_button3
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t cfg;

  logic             in_valid_q;
  logic             in_func_q;
  logic [PIN_W-1:0] in_pins_q;
  logic             out_valid_q;
  logic [7:0]       out_data_q;
  logic [7:0]       out_data_d;
  logic             out_free;
  logic             advance;

  bsl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser;
      in_pins_q <= s_axis_tdata[PIN_W-1:0];
    end
  end

  // one machine per button with an event field
  for (genvar i = 0; i < OUT_FIELDS; i++) begin : g_btn
    if (i < NUM_BUTTONS) begin : g_fsm
      logic            released;
      logic [EV_W-1:0] ev;
      if (i < PIN_W) begin : g_pin
        assign released = in_pins_q[i];
      end else begin : g_nopin
        assign released = 1'b1;
      end
      bsl_button_fsm u_fsm (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .step_i     (advance),
        .func_i     (in_func_q),
        .released_i (released),
        .cfg_i      (cfg),
        .event_o    (ev)
      );
      assign out_data_d[i*EV_W +: EV_W] = ev;
    end else begin : g_none
      assign out_data_d[i*EV_W +: EV_W] = EV_NONE;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/bsl_checker.sv @@
// port-level checker for the button press detector, with its bind
module bsl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // no event field ever carries the unused code
  a_ev_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[3:2] != 2'd3)
                   && (m_axis_tdata[5:4] != 2'd3) && (m_axis_tdata[7:6] != 2'd3))
    else $error("event field with unused code");

  // input backs up only behind a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a result leaves only after it was taken
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without being taken");

endmodule

bind button_short_long_press_detector bsl_checker u_bsl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
